>>> rtl/core/rolz_token_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// rolz_token_decoder_top_assert.svh
// Assertion macros for the ROLZ token decoder.
// ----------------------------------------------------------------------------
`ifndef ROLZ_TOKEN_DECODER_TOP_ASSERT_SVH
`define ROLZ_TOKEN_DECODER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RTD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rtd: assertion failed");
`define RTD_ASSERT_ANY(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rtd: assertion failed");
`else
`define RTD_ASSERT(lbl, prop)
`define RTD_ASSERT_ANY(lbl, prop)
`endif
`endif

>>> rtl/core/rtd_pkg.sv
// ----------------------------------------------------------------------------
// rtd_pkg
// Types, constants and controller codes of the ROLZ token decoder.
// ----------------------------------------------------------------------------
package rtd_pkg;

    localparam int HISTORY_BYTES_DEF = 65536;
    localparam int RING_ENTRIES_DEF  = 4096;
    localparam int CONTEXTS          = 256;
    localparam int LEN_MIN           = 4;
    localparam int LEN_MAX           = 131;
    localparam int PACK_BYTES        = 8;

    typedef struct packed {
        logic        block_start;
        logic        is_match;
        logic [7:0]  literal_byte;
        logic [7:0]  match_length;
        logic [11:0] match_index;
        logic        chunk_end;
    } token_t;

    typedef struct packed {
        logic [63:0] packed_bytes;
        logic [3:0]  byte_count;
        logic        last;
        logic        chunk_done;
        logic        overrun;
        logic [16:0] decoded_total;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_HEAD,
        ST_RING,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_EMIT,
        ST_EMIT_LAST
    } state_t;

    typedef struct packed {
        logic take;
        logic decide;
        logic wr_first;
        logic wr_lit;
        logic mark_ovf;
        logic head_rd;
        logic push;
        logic ring_rd;
        logic src_load;
        logic copy_rd;
        logic copy_wr;
        logic emit;
        logic emit_last;
    } cmd_t;

    typedef struct packed {
        logic first;
        logic ovf;
        logic is_match;
        logic copy_done;
        logic word_full;
        logic out_free;
    } status_t;

endpackage

>>> rtl/core/rolz_token_decoder_top.sv
// ----------------------------------------------------------------------------
// rolz_token_decoder_top
// ROLZ token decoder: literal and match tokens in, packed decoded bytes out.
// ----------------------------------------------------------------------------
// Input channel tok/tok_valid/tok_stall carries one token per transaction;
// output channel res/res_valid/res_stall carries up to eight decoded bytes
// per transaction, first byte in the low bits.
// One token is decoded at a time; tok_stall is high while a token is at work.
// A literal token passes through the decide, head and final-emit states; a
// first-of-block or overrun token goes from decide straight to final emit.
// A match goes on through the ring read and then alternates copy reads and
// copy writes, emitting a result whenever eight bytes are packed: every
// copied byte is one history read and one history write. The next token can
// be taken in the cycle after the final result is loaded.
// The result register frees the copy engine as soon as a result is loaded;
// while res_stall is high the result holds and decoding pauses at the next
// result. Reset clears the position and all ring heads at once; no sweep
// of the history or ring memories is needed.
// ----------------------------------------------------------------------------
module rolz_token_decoder_top
    import rtd_pkg::*;
#(
    parameter int HISTORY_BYTES = HISTORY_BYTES_DEF,
    parameter int RING_ENTRIES  = RING_ENTRIES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    tok_valid,
    output logic    tok_stall,
    input  token_t  tok,
    output logic    res_valid,
    input  logic    res_stall,
    output result_t res
);

    cmd_t    cmd;
    status_t st;

    rtd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .st        (st),
        .cmd       (cmd)
    );

    rtd_dp #(
        .HISTORY_BYTES (HISTORY_BYTES),
        .RING_ENTRIES  (RING_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .tok       (tok),
        .res       (res),
        .res_valid (res_valid),
        .res_stall (res_stall)
    );

endmodule

>>> rtl/core/rtd_ctrl.sv
// ----------------------------------------------------------------------------
// rtd_ctrl
// Token sequencer: steps the datapath through decode, ring update and copy.
// ----------------------------------------------------------------------------
module rtd_ctrl
    import rtd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    tok_valid,
    output logic    tok_stall,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tok_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (st.first || st.ovf)
                begin
                    state_next = ST_EMIT_LAST;
                end
                else
                begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                state_next = st.is_match ? ST_RING : ST_EMIT_LAST;
            end
            ST_RING:
            begin
                state_next = ST_COPY_RD;
            end
            ST_COPY_RD:
            begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                if (st.copy_done)
                begin
                    state_next = ST_EMIT_LAST;
                end
                else if (st.word_full)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_COPY_RD;
                end
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    state_next = ST_COPY_RD;
                end
            end
            ST_EMIT_LAST:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        tok_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take = tok_valid;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (st.first)
                begin
                    cmd.wr_first = 1'b1;
                end
                else if (st.ovf)
                begin
                    cmd.mark_ovf = 1'b1;
                end
                else
                begin
                    cmd.head_rd = 1'b1;
                    cmd.wr_lit  = !st.is_match;
                end
            end
            ST_HEAD:
            begin
                cmd.push    = 1'b1;
                cmd.ring_rd = st.is_match;
            end
            ST_RING:
            begin
                cmd.src_load = 1'b1;
            end
            ST_COPY_RD:
            begin
                cmd.copy_rd = 1'b1;
            end
            ST_COPY_WR:
            begin
                cmd.copy_wr = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = st.out_free;
            end
            ST_EMIT_LAST:
            begin
                cmd.emit_last = st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/rtd_dp.sv
// ----------------------------------------------------------------------------
// rtd_dp
// Decoder datapath: history, context rings, copy engine and result register.
// ----------------------------------------------------------------------------
`include "rolz_token_decoder_top_assert.svh"
module rtd_dp
    import rtd_pkg::*;
#(
    parameter int HISTORY_BYTES = HISTORY_BYTES_DEF,
    parameter int RING_ENTRIES  = RING_ENTRIES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    output status_t st,
    input  token_t  tok,
    output result_t res,
    output logic    res_valid,
    input  logic    res_stall
);

    localparam int HA_W       = $clog2(HISTORY_BYTES);
    localparam int POS_W      = $clog2(HISTORY_BYTES + 1);
    localparam int SUM_W      = POS_W + 2;
    localparam int NODE_W     = $clog2(RING_ENTRIES);
    localparam int RA_W       = 8 + NODE_W;
    localparam int RING_DEPTH = CONTEXTS * RING_ENTRIES;
    localparam int MOD_W      = 20;

    logic [7:0]        hist_mem [HISTORY_BYTES];
    logic [NODE_W:0]   head_mem [CONTEXTS];
    logic [HA_W-1:0]   ring_mem [RING_DEPTH];

    token_t            tok_reg;
    logic [POS_W-1:0]  wpos_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [7:0]        ctx_reg;
    logic [7:0]        last_byte_reg;
    logic [7:0]        len_reg;
    logic [7:0]        cnt_reg;
    logic [HA_W-1:0]   src_reg;
    logic [63:0]       word_reg;
    logic [3:0]        wcnt_reg;
    logic              ovf_reg;
    logic [CONTEXTS-1:0] hvalid_reg;
    logic [NODE_W:0]   head_q_reg;
    logic [HA_W-1:0]   ring_q_reg;
    logic              rvalid_reg;
    logic [7:0]        hist_q_reg;
    result_t           res_reg;
    logic              res_valid_reg;

    logic [POS_W-1:0]  pos_eff;
    logic [7:0]        len_clamp;
    logic              lit_ovf;
    logic              match_ovf;
    logic [MOD_W-1:0]  mod_r;
    logic [NODE_W-1:0] k;
    logic [NODE_W-1:0] h;
    logic              wrapped;
    logic [NODE_W-1:0] newhead;
    logic [NODE_W:0]   node_ext;
    logic [NODE_W-1:0] node;
    logic [RA_W-1:0]   wr_addr;
    logic [RA_W-1:0]   rd_addr;
    logic [HA_W-1:0]   src_raw;
    logic [HA_W-1:0]   src_fix;

    assign pos_eff = tok_reg.block_start ? '0 : wpos_reg;

    always_comb
    begin
        if (tok_reg.match_length < 8'(LEN_MIN))
        begin
            len_clamp = 8'(LEN_MIN);
        end
        else if (tok_reg.match_length > 8'(LEN_MAX))
        begin
            len_clamp = 8'(LEN_MAX);
        end
        else
        begin
            len_clamp = tok_reg.match_length;
        end
    end

    assign lit_ovf   = SUM_W'(pos_eff) >= SUM_W'(HISTORY_BYTES);
    assign match_ovf = (SUM_W'(pos_eff) + SUM_W'(len_clamp)) > SUM_W'(HISTORY_BYTES);

    always_comb
    begin
        mod_r = MOD_W'(tok_reg.match_index);
        for (int s = 7; s >= 0; s--)
        begin
            if (mod_r >= (MOD_W'(RING_ENTRIES) << s))
            begin
                mod_r = mod_r - (MOD_W'(RING_ENTRIES) << s);
            end
        end
    end

    assign k        = NODE_W'(mod_r);
    assign h        = hvalid_reg[ctx_reg] ? head_q_reg[NODE_W-1:0] : '0;
    assign wrapped  = hvalid_reg[ctx_reg] & head_q_reg[NODE_W];
    assign newhead  = (h == NODE_W'(RING_ENTRIES - 1)) ? '0 : h + 1'b1;
    assign node_ext = (h >= k) ? {1'b0, h} - {1'b0, k}
                               : {1'b0, h} + (NODE_W + 1)'(RING_ENTRIES) - {1'b0, k};
    assign node     = node_ext[NODE_W-1:0];
    assign wr_addr  = RA_W'(ctx_reg) * RA_W'(RING_ENTRIES) + RA_W'(newhead);
    assign rd_addr  = RA_W'(ctx_reg) * RA_W'(RING_ENTRIES) + RA_W'(node);

    assign src_raw  = rvalid_reg ? ring_q_reg : '0;
    assign src_fix  = (POS_W'(src_raw) >= pos_reg) ? HA_W'(pos_reg - 1'b1) : src_raw;

    assign st.first     = (pos_eff == '0);
    assign st.ovf       = tok_reg.is_match ? match_ovf : lit_ovf;
    assign st.is_match  = tok_reg.is_match;
    assign st.copy_done = ((cnt_reg + 8'd1) == len_reg);
    assign st.word_full = (wcnt_reg == 4'(PACK_BYTES - 1));
    assign st.out_free  = !res_valid_reg || !res_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_first)
        begin
            hist_mem[0] <= tok_reg.literal_byte;
        end
        else if (cmd.wr_lit)
        begin
            hist_mem[HA_W'(pos_eff)] <= tok_reg.literal_byte;
        end
        else if (cmd.copy_wr)
        begin
            hist_mem[HA_W'(pos_reg + POS_W'(cnt_reg))] <= hist_q_reg;
        end
        if (cmd.copy_rd)
        begin
            hist_q_reg <= hist_mem[src_reg + HA_W'(cnt_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.head_rd)
        begin
            head_q_reg <= head_mem[last_byte_reg];
        end
        if (cmd.push)
        begin
            head_mem[ctx_reg] <= {wrapped | (newhead == '0), newhead};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            ring_mem[wr_addr] <= HA_W'(pos_reg);
        end
        if (cmd.ring_rd)
        begin
            ring_q_reg <= ring_mem[rd_addr];
            rvalid_reg <= wrapped || ((node != '0) && (node <= h));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            tok_reg <= tok;
        end
        if (cmd.decide)
        begin
            pos_reg <= pos_eff;
            ctx_reg <= last_byte_reg;
            len_reg <= len_clamp;
        end
        if (cmd.src_load)
        begin
            src_reg <= src_fix;
        end
        if (cmd.emit || cmd.emit_last)
        begin
            res_reg.packed_bytes  <= word_reg;
            res_reg.byte_count    <= wcnt_reg;
            res_reg.last          <= cmd.emit_last;
            res_reg.chunk_done    <= cmd.emit_last & tok_reg.chunk_end;
            res_reg.overrun       <= ovf_reg;
            res_reg.decoded_total <= 17'(wpos_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg      <= '0;
            last_byte_reg <= '0;
            cnt_reg       <= '0;
            word_reg      <= '0;
            wcnt_reg      <= '0;
            ovf_reg       <= 1'b0;
            hvalid_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                ovf_reg  <= 1'b0;
                word_reg <= '0;
                wcnt_reg <= '0;
            end
            if (cmd.decide && tok_reg.block_start)
            begin
                hvalid_reg <= '0;
            end
            if (cmd.wr_first)
            begin
                wpos_reg      <= POS_W'(1);
                last_byte_reg <= tok_reg.literal_byte;
                word_reg      <= 64'(tok_reg.literal_byte);
                wcnt_reg      <= 4'd1;
            end
            if (cmd.wr_lit)
            begin
                wpos_reg      <= pos_eff + 1'b1;
                last_byte_reg <= tok_reg.literal_byte;
                word_reg      <= 64'(tok_reg.literal_byte);
                wcnt_reg      <= 4'd1;
            end
            if (cmd.head_rd && tok_reg.is_match)
            begin
                wpos_reg <= pos_eff + POS_W'(len_clamp);
            end
            if (cmd.mark_ovf)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.push)
            begin
                hvalid_reg[ctx_reg] <= 1'b1;
            end
            if (cmd.src_load)
            begin
                cnt_reg <= '0;
            end
            if (cmd.copy_wr)
            begin
                word_reg      <= word_reg | (64'(hist_q_reg) << {wcnt_reg[2:0], 3'b000});
                wcnt_reg      <= wcnt_reg + 4'd1;
                last_byte_reg <= hist_q_reg;
                cnt_reg       <= cnt_reg + 8'd1;
            end
            if (cmd.emit || cmd.emit_last)
            begin
                res_valid_reg <= 1'b1;
                word_reg      <= '0;
                wcnt_reg      <= '0;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    `RTD_ASSERT(a_full_word, res_valid && !res.last |-> res.byte_count == 4'd8)
    `RTD_ASSERT(a_ovf_empty, res_valid && res.overrun |-> res.last && res.byte_count == 4'd0)
    `RTD_ASSERT(a_src_behind, cmd.copy_rd |-> POS_W'(src_reg) < pos_reg)
    `RTD_ASSERT_ANY(a_word_cap, wcnt_reg <= 4'd8)

endmodule
